@@ rtl/status_led_blink_frame_gen_core_assert.svh @@
// assertion macros shared by the status led frame generator
`ifndef STATUS_LED_BLINK_FRAME_GEN_CORE_ASSERT_SVH
`define STATUS_LED_BLINK_FRAME_GEN_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/slbf_pkg.sv @@
// types and constants of the status led frame generator
`timescale 1ns / 1ps

package slbf_pkg;

    localparam int START_BYTES = 4;
    localparam int START_W     = $clog2(START_BYTES);
    localparam int IDX_W       = 3;
    localparam int MODE_W      = 2;
    localparam int COLOR_W     = 4;
    localparam int LEVEL_W     = 5;
    localparam int PHASE_W     = 7;
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 4;
    localparam int IN_DATA_W   = 16;

    localparam logic [CFG_W-1:0] STRIP_LEN_RST = 4'd5;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_NONE    = 4'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED     = 4'd1;
    localparam logic [COLOR_W-1:0] COLOR_ORANGE  = 4'd2;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW  = 4'd3;
    localparam logic [COLOR_W-1:0] COLOR_GREEN   = 4'd4;
    localparam logic [COLOR_W-1:0] COLOR_AQUA    = 4'd5;
    localparam logic [COLOR_W-1:0] COLOR_BLUE    = 4'd6;
    localparam logic [COLOR_W-1:0] COLOR_MAGENTA = 4'd7;
    localparam logic [COLOR_W-1:0] COLOR_WHITE   = 4'd8;

    localparam logic [PHASE_W-1:0] STEP_WRAP  = 7'h66;
    localparam logic [PHASE_W-1:0] STEP_HALF  = 7'h33;
    localparam logic [BYTE_W-1:0]  HDR_BITS   = 8'hE0;
    localparam logic [BYTE_W-1:0]  FULL_LEVEL = 8'hFF;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COLOR_W-1:0] color;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
    } t_entry;

    typedef struct packed {
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } t_pix;

endpackage

@@ rtl/slbf_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module slbf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slbf_pixel.sv @@
// per-led blink step update and header/color byte generation
`timescale 1ns / 1ps

module slbf_pixel (
    input  slbf_pkg::t_entry                  i_entry,
    output slbf_pkg::t_pix                    o_pix,
    output logic [slbf_pkg::PHASE_W-1:0]      o_phase
);

    import slbf_pkg::*;

    function automatic t_pix paint(input logic [COLOR_W-1:0] col, input logic [BYTE_W-1:0] v);
        t_pix p;
        p = '0;
        unique case (col)
            COLOR_RED: begin
                p.red = v;
            end
            COLOR_ORANGE: begin
                p.green = {1'b0, v[BYTE_W-1:1]};
                p.red   = v;
            end
            COLOR_YELLOW: begin
                p.green = v;
                p.red   = v;
            end
            COLOR_GREEN: begin
                p.green = v;
            end
            COLOR_AQUA: begin
                p.blue  = v;
                p.green = v;
            end
            COLOR_BLUE: begin
                p.blue = v;
            end
            COLOR_MAGENTA: begin
                p.blue = v;
                p.red  = v;
            end
            COLOR_WHITE: begin
                p.blue  = v;
                p.green = v;
                p.red   = v;
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    logic [PHASE_W-1:0] step;
    logic [PHASE_W-1:0] down;
    logic [PHASE_W+1:0] step5;
    logic [PHASE_W+1:0] down5;
    logic [BYTE_W-1:0]  blink_lvl;
    logic               col_ok;

    always_comb begin
        step = (i_entry.phase < STEP_WRAP) ? PHASE_W'(i_entry.phase + 1'b1) : '0;
        down = PHASE_W'(step - STEP_HALF);
        // times five as shift and add
        step5 = {step, 2'b00} + {2'b00, step};
        down5 = {down, 2'b00} + {2'b00, down};
        blink_lvl = (step < STEP_HALF) ? step5[BYTE_W-1:0] : BYTE_W'(FULL_LEVEL - down5[BYTE_W-1:0]);
        col_ok = (i_entry.color >= COLOR_RED) && (i_entry.color <= COLOR_WHITE);

        o_pix     = '0;
        o_pix.hdr = HDR_BITS;
        o_phase   = i_entry.phase;
        unique case (i_entry.mode)
            MODE_ON: begin
                o_pix     = paint(i_entry.color, FULL_LEVEL);
                o_pix.hdr = HDR_BITS | {3'b000, i_entry.level};
            end
            MODE_BLINK: begin
                o_phase   = step;
                o_pix     = paint(i_entry.color, blink_lvl);
                o_pix.hdr = col_ok ? (HDR_BITS | {3'b000, i_entry.level}) : HDR_BITS;
            end
            default: begin
                // off, and the unused mode code shows as off too
            end
        endcase
    end

endmodule

@@ rtl/status_led_blink_frame_gen_core.sv @@
// top level: command decode, frame sequencer and led state memory
`timescale 1ns / 1ps

`include "status_led_blink_frame_gen_core_assert.svh"

// Status LED frame generator. A set-status beat (tuser 0) updates one LED
// entry in the state RAM. A tick beat (tuser 1) emits a whole frame of
// 4 + 4*n + ceil(n/2) bytes, n the driven LED count, into an output register.
// For each LED the state RAM is read, then the entry is computed and written
// back, before its four bytes go out; output stalls hold the frame, and the
// input takes no new beat until the frame is done. The input side accepts
// the next beat as soon as the last end byte sits in the output register.
module status_led_blink_frame_gen_core #(
    parameter int MAX_LEDS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // number of driven leds
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [slbf_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // led_index[2:0], mode[4:3], color[8:5], brightness[13:9], zero pad
    input  logic [slbf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd[0]
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // frame_byte[7:0]
    output logic [slbf_pkg::BYTE_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tlast
);

    import slbf_pkg::*;

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int CTR_W = (CNT_W > START_W) ? CNT_W : START_W;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_RD    = 9'b000000100,
        ST_CALC  = 9'b000001000,
        ST_HDR   = 9'b000010000,
        ST_BLU   = 9'b000100000,
        ST_GRN   = 9'b001000000,
        ST_RED   = 9'b010000000,
        ST_ENDB  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_led_cnt;
    logic [CTR_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_idx, n_idx;
    t_pix                 r_pix, n_pix;
    logic [MAX_LEDS-1:0]  r_valid, n_valid;
    logic                 r_rd_valid, n_rd_valid;
    logic                 r_m_valid, n_m_valid;
    logic [BYTE_W-1:0]    r_m_data, n_m_data;
    logic                 r_m_last, n_m_last;

    logic [CNT_W-1:0]     drv_cnt;
    logic [CNT_W:0]       drv_p1;
    logic [CNT_W-1:0]     end_cnt;

    logic [IDX_W-1:0]     in_idx;
    logic [MODE_W-1:0]    in_mode;
    logic [COLOR_W-1:0]   in_color;
    logic [LEVEL_W-1:0]   in_level;
    logic                 in_acc;
    logic                 adv;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_entry               ram_wdata;
    logic                 ram_re;
    logic [ENT_W-1:0]     ram_rdata;
    t_entry               cur_entry;
    t_pix                 calc_pix;
    logic [PHASE_W-1:0]   calc_phase;

    logic                 emit;
    logic [BYTE_W-1:0]    emit_data;
    logic                 emit_last;

    assign in_idx   = s_axis_tdata[2:0];
    assign in_mode  = s_axis_tdata[4:3];
    assign in_color = s_axis_tdata[8:5];
    assign in_level = s_axis_tdata[13:9];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign adv           = !r_m_valid || m_axis_tready;

    // driven count: zero counts as one, clamp at MAX_LEDS
    always_comb begin
        priority if (r_led_cnt == '0) begin
            drv_cnt = CNT_W'(1);
        end else if (5'(r_led_cnt) > 5'(MAX_LEDS)) begin
            drv_cnt = CNT_W'(MAX_LEDS);
        end else begin
            drv_cnt = CNT_W'(r_led_cnt);
        end
    end

    assign drv_p1  = {1'b0, drv_cnt} + (CNT_W + 1)'(1);
    assign end_cnt = drv_p1[CNT_W:1];

    // entries never written read as the reset state
    assign cur_entry = r_rd_valid ? t_entry'(ram_rdata) : t_entry'('0);

    slbf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LEDS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    slbf_pixel u_pixel (
        .i_entry (cur_entry),
        .o_pix   (calc_pix),
        .o_phase (calc_phase)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_pix      = r_pix;
        n_valid    = r_valid;
        n_rd_valid = r_rd_valid;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        n_m_last   = r_m_last;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wdata  = cur_entry;
        ram_re     = 1'b0;
        emit       = 1'b0;
        emit_data  = '0;
        emit_last  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] == CMD_TICK) begin
                        n_cnt   = '0;
                        n_state = ST_START;
                    end else if (CMP_W'(in_idx) < CMP_W'(drv_cnt)) begin
                        ram_we          = 1'b1;
                        ram_waddr       = AW'(in_idx);
                        ram_wdata.mode  = in_mode;
                        ram_wdata.color = in_color;
                        ram_wdata.level = in_level;
                        ram_wdata.phase = '0;
                        n_valid[AW'(in_idx)] = 1'b1;
                    end
                end
            end
            ST_START: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_cnt == CTR_W'(START_BYTES - 1)) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = ST_RD;
                    end else begin
                        n_cnt = CTR_W'(r_cnt + 1'b1);
                    end
                end
            end
            ST_RD: begin
                ram_re     = 1'b1;
                n_rd_valid = r_valid[r_idx[AW-1:0]];
                n_state    = ST_CALC;
            end
            ST_CALC: begin
                // write the advanced blink step back, bytes go to r_pix
                n_pix           = calc_pix;
                ram_we          = 1'b1;
                ram_wdata.phase = calc_phase;
                n_valid[r_idx[AW-1:0]] = 1'b1;
                n_state         = ST_HDR;
            end
            ST_HDR: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_data = r_pix.hdr;
                    n_state   = ST_BLU;
                end
            end
            ST_BLU: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_data = r_pix.blue;
                    n_state   = ST_GRN;
                end
            end
            ST_GRN: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_data = r_pix.green;
                    n_state   = ST_RED;
                end
            end
            ST_RED: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_data = r_pix.red;
                    if (r_idx == CNT_W'(drv_cnt - 1'b1)) begin
                        n_cnt   = '0;
                        n_state = ST_ENDB;
                    end else begin
                        n_idx   = CNT_W'(r_idx + 1'b1);
                        n_state = ST_RD;
                    end
                end
            end
            ST_ENDB: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_cnt == CTR_W'(CTR_W'(end_cnt) - CTR_W'(1))) begin
                        emit_last = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_cnt = CTR_W'(r_cnt + 1'b1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_m_valid = 1'b1;
            n_m_data  = emit_data;
            n_m_last  = emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_led_cnt  <= STRIP_LEN_RST;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_valid    <= n_valid;
            r_rd_valid <= n_rd_valid;
            r_m_valid  <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_led_cnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix    <= n_pix;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    `SLBF_ASSERT_IMP(a_last_is_end_byte, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == '0, "last beat carries a nonzero byte")
    `SLBF_ASSERT_IMP(a_wb_phase_range, i_clk, i_rst_n, ram_we && (r_state == ST_CALC), ram_wdata.phase <= STEP_WRAP, "blink step written back out of range")
    `SLBF_ASSERT_IMP(a_led_idx_range, i_clk, i_rst_n, (r_state != ST_IDLE) && (r_state != ST_START) && (r_state != ST_ENDB), r_idx < drv_cnt, "led walk beyond driven count")
    `SLBF_ASSERT_NEXT(a_tick_starts_frame, i_clk, i_rst_n, in_acc && (s_axis_tuser[0] == CMD_TICK), (r_state == ST_START) && !s_axis_tready, "tick did not start a frame")

endmodule

@@ test/tb.sv @@
// testbench for the status led frame generator: set-status and tick beats against a frame predictor
`timescale 1ns / 1ps

module tb;
    import slbf_pkg::*;

    localparam int MAX_LEDS   = 8;
    localparam int STALL_MAX  = 2000;
    localparam int SETTLE_CYC = 8;
    localparam int TAIL_CYC   = 64;

    // codes the package leaves unnamed
    localparam logic [MODE_W-1:0]  MODE_RSVD = 2'd3;
    localparam logic [COLOR_W-1:0] COLOR_BAD = 4'd15;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_frame_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    // shadow of the led strip state
    logic [CFG_W-1:0]   strip_len;
    logic [MODE_W-1:0]  shadow_mode  [MAX_LEDS];
    logic [COLOR_W-1:0] shadow_color [MAX_LEDS];
    logic [LEVEL_W-1:0] shadow_level [MAX_LEDS];
    logic [PHASE_W-1:0] shadow_phase [MAX_LEDS];

    t_frame_beat frame_bytes_due[$];
    int          errors = 0;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          quiet_cycles = 0;

    status_led_blink_frame_gen_core #(
        .MAX_LEDS(MAX_LEDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic int driven_leds();
        int n;
        n = strip_len;
        if (n < 1) n = 1;
        if (n > MAX_LEDS) n = MAX_LEDS;
        return n;
    endfunction

    // blue, green, red for a color index at level v
    function automatic logic [23:0] paint(logic [COLOR_W-1:0] col, logic [7:0] v);
        logic [7:0] b, g, r;
        b = 8'd0;
        g = 8'd0;
        r = 8'd0;
        case (col)
            COLOR_RED:     r = v;
            COLOR_ORANGE: begin g = v >> 1; r = v; end
            COLOR_YELLOW: begin g = v; r = v; end
            COLOR_GREEN:   g = v;
            COLOR_AQUA:   begin b = v; g = v; end
            COLOR_BLUE:    b = v;
            COLOR_MAGENTA: begin b = v; r = v; end
            COLOR_WHITE:  begin b = v; g = v; r = v; end
            default: ;
        endcase
        return {b, g, r};
    endfunction

    function automatic void push_byte(logic [7:0] data, logic last);
        t_frame_beat fb;
        fb.data = data;
        fb.last = last;
        frame_bytes_due.push_back(fb);
    endfunction

    // update the shadow state for one accepted beat and queue the frame it causes
    function automatic void predict_frame(logic cmd, logic [IDX_W-1:0] idx,
                                          logic [MODE_W-1:0] mode, logic [COLOR_W-1:0] col,
                                          logic [LEVEL_W-1:0] level);
        int          n, ends, v;
        logic [7:0]  hdr;
        logic [23:0] bgr;
        logic [PHASE_W-1:0] s;
        n = driven_leds();
        if (cmd == CMD_SET) begin
            if (idx < n) begin
                shadow_mode[idx]  = mode;
                shadow_color[idx] = col;
                shadow_level[idx] = level;
                shadow_phase[idx] = '0;
            end
            return;
        end
        for (int i = 0; i < START_BYTES; i++) push_byte(8'h00, 1'b0);
        for (int i = 0; i < n; i++) begin
            hdr = HDR_BITS;
            bgr = '0;
            if (shadow_mode[i] == MODE_ON) begin
                bgr = paint(shadow_color[i], FULL_LEVEL);
                hdr = HDR_BITS | shadow_level[i];
            end else if (shadow_mode[i] == MODE_BLINK) begin
                s = (shadow_phase[i] < STEP_WRAP) ? shadow_phase[i] + 7'd1 : 7'd0;
                shadow_phase[i] = s;
                v = (s < STEP_HALF) ? s * 5 : FULL_LEVEL - (s - STEP_HALF) * 5;
                if (shadow_color[i] >= COLOR_RED && shadow_color[i] <= COLOR_WHITE) begin
                    bgr = paint(shadow_color[i], 8'(v));
                    hdr = HDR_BITS | shadow_level[i];
                end
            end
            push_byte(hdr, 1'b0);
            push_byte(bgr[23:16], 1'b0);
            push_byte(bgr[15:8], 1'b0);
            push_byte(bgr[7:0], 1'b0);
        end
        ends = (n + 1) / 2;
        for (int i = 0; i < ends; i++) push_byte(8'h00, i + 1 == ends);
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_frame_beat fb;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("unexpected frame byte", m_axis_tdata, 8'h00);
            end else begin
                fb = frame_bytes_due.pop_front();
                if (m_axis_tdata !== fb.data)
                    report_mismatch("frame_byte", m_axis_tdata, fb.data);
                if (m_axis_tlast !== fb.last)
                    report_mismatch("last", {7'd0, m_axis_tlast}, {7'd0, fb.last});
            end
        end
    end

    // watchdog: cycles without any beat on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("status_led_blink_frame_gen_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ---------------- drivers ----------------

    task automatic send_beat(logic cmd, logic [IDX_W-1:0] idx, logic [MODE_W-1:0] mode,
                             logic [COLOR_W-1:0] col, logic [LEVEL_W-1:0] level);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {2'b00, level, col, mode, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(cmd, idx, mode, col, level);
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, IDX_W'($urandom), MODE_W'($urandom), COLOR_W'($urandom),
                  LEVEL_W'($urandom));
    endtask

    // stop sending and wait until every queued frame byte has come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_strip_len(logic [CFG_W-1:0] len);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = len;
        do @(posedge i_clk); while (!o_cfg_ready);
        strip_len = len;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = CFG_W'($urandom);
    endtask

    // ---------------- tests ----------------

    // reset state: five dark leds
    task automatic test_reset_frame();
        send_tick();
    endtask

    task automatic test_led_modes();
        send_beat(CMD_SET, 3'd0, MODE_ON, COLOR_RED, 5'd31);
        send_beat(CMD_SET, 3'd1, MODE_BLINK, COLOR_ORANGE, 5'd0);
        // steady on without a color still shows its level
        send_beat(CMD_SET, 3'd2, MODE_ON, COLOR_NONE, 5'd17);
        send_beat(CMD_SET, 3'd3, MODE_RSVD, COLOR_WHITE, 5'd31);
        send_beat(CMD_SET, 3'd4, MODE_BLINK, COLOR_BAD, 5'd31);
        // indexes at and past the driven count are dropped
        send_beat(CMD_SET, 3'd5, MODE_ON, COLOR_WHITE, 5'd31);
        send_beat(CMD_SET, 3'd7, MODE_ON, COLOR_WHITE, 5'd31);
        send_tick();
        send_tick();
    endtask

    task automatic test_palette();
        write_strip_len(4'd8);
        for (int i = 0; i < MAX_LEDS; i++)
            send_beat(CMD_SET, IDX_W'(i), MODE_ON, COLOR_W'(COLOR_RED + i), LEVEL_W'(i * 4 + 3));
        send_tick();
        send_beat(CMD_SET, 3'd6, MODE_OFF, COLOR_WHITE, 5'd31);
        send_beat(CMD_SET, 3'd7, MODE_BLINK, COLOR_AQUA, 5'd9);
        send_tick();
    endtask

    // one blinking led run past the step wrap
    task automatic test_blink_wrap();
        write_strip_len(4'd1);
        send_beat(CMD_SET, 3'd0, MODE_BLINK, COLOR_WHITE, 5'd21);
        for (int i = 0; i < 104; i++) send_tick();
    endtask

    task automatic test_random_traffic(int n_items, logic [CFG_W-1:0] len, bit hold_off);
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [COLOR_W-1:0] col;
        int                n;
        write_strip_len(len);
        n = driven_leds();
        for (int k = 0; k < n_items; k++) begin
            cmd = ($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_SET;
            idx = ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, n - 1))
                                                : IDX_W'($urandom);
            col = ($urandom_range(0, 99) < 75) ? COLOR_W'($urandom_range(0, 8))
                                                : COLOR_W'($urandom);
            send_beat(cmd, idx, MODE_W'($urandom), col, LEVEL_W'($urandom));
            if (hold_off && k == n_items / 2) drain();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        src_idle_pct  = 16;
        snk_idle_pct  = 59;
        strip_len     = STRIP_LEN_RST;
        for (int i = 0; i < MAX_LEDS; i++) begin
            shadow_mode[i]  = MODE_OFF;
            shadow_color[i] = COLOR_NONE;
            shadow_level[i] = '0;
            shadow_phase[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_frame();
        test_led_modes();
        test_palette();
        test_random_traffic(8, 4'd0, 1'b1);

        src_idle_pct = 59;
        snk_idle_pct = 16;
        test_random_traffic(8, 4'd15, 1'b0);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_blink_wrap();
        test_random_traffic(8, CFG_W'($urandom_range(1, 8)), 1'b0);

        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (frame_bytes_due.size() != 0)
            report_mismatch("bytes never sent", 8'(frame_bytes_due.size()), 8'h00);
        if (errors == 0) begin
            $display("status_led_blink_frame_gen_core test passed");
        end else begin
            $display("status_led_blink_frame_gen_core test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/slbf_pkg.sv
rtl/slbf_ram.sv
rtl/slbf_pixel.sv
rtl/status_led_blink_frame_gen_core.sv
test/tb.sv
